### rtl/tpurc_pkg.sv
// Shared types and constants for the two-peer UDP relay classifier.
package tpurc_pkg;

    typedef enum logic [2:0] {
        VERDICT_DROP       = 3'd0,
        VERDICT_HEALTH     = 3'd1,
        VERDICT_REGISTERED = 3'd2,
        VERDICT_WAITING    = 3'd3,
        VERDICT_FORWARD    = 3'd4
    } verdict_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic        slot_index;
    } result_t;

    // Configuration register indexes
    localparam logic CFG_TOKEN_HIGH = 1'b0;
    localparam logic CFG_TOKEN_LOW  = 1'b1;

    localparam logic [5:0] HEALTH_LEN = 6'd4;
    localparam logic [5:0] REG_LEN    = 6'd36;
    localparam logic [5:0] COUNT_SAT  = 6'd37;
    localparam logic [5:0] MAGIC_LEN  = 6'd4;

    // "SF4H" and "SF4G", first character at index 0
    localparam logic [7:0] HEALTH_MAGIC [4] = '{8'h53, 8'h46, 8'h34, 8'h48};
    localparam logic [7:0] REG_MAGIC    [4] = '{8'h53, 8'h46, 8'h34, 8'h47};

    // Lower-case ASCII hex character for one token nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'h0, nib};
        else
            ch = 8'h57 + {4'h0, nib};
        return ch;
    endfunction

    // Fold 'A'..'Z' down to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] ch;
        if (b >= 8'h41 && b <= 8'h5A)
            ch = b + 8'h20;
        else
            ch = b;
        return ch;
    endfunction

endpackage

### rtl/two_peer_udp_relay_classifier_top.sv
// Top level of the two-peer UDP relay classifier: byte matcher, slot table and result buffer.
//
// Channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------------
// in       | in_valid / in_ready   | data_byte, src_ip, src_port, first_byte, last_byte
// out      | out_valid / out_ready | verdict, dest_ip, dest_port, slot_index
// cfg      | cfg_write_en          | cfg_index, cfg_wdata (no wait, no read-back)
//
// One byte is taken per cycle while in_ready is high. When the last byte of a datagram
// is transferred, its verdict is registered into the output register, or into the skid
// register while the output register is held. The match logic in between is combinational.
// Reset (rst_n low, asynchronous) clears the token, the datagram state and both slots.
// A result waiting on out_ready parks in a one-entry skid register; in_ready falls only
// while that skid register is full.
module two_peer_udp_relay_classifier_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic [31:0]          src_ip,
    input  logic [15:0]          src_port,
    input  logic                 first_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tpurc_pkg::verdict_t  verdict,
    output logic [31:0]          dest_ip,
    output logic [15:0]          dest_port,
    output logic                 slot_index,
    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_wdata
);
    import tpurc_pkg::*;

    // Configuration
    logic [63:0] token_high_reg;
    logic [63:0] token_low_reg;

    // Per-datagram state
    logic [5:0]  byte_count_reg,  byte_count_next;
    logic        health_ok_reg,   health_ok_next;
    logic        reg_ok_reg,      reg_ok_next;
    logic        token_ok_reg,    token_ok_next;

    // Slot table: endpoint is {ip, port}
    logic [47:0] slot_ep_reg     [2];
    logic [47:0] slot_ep_next    [2];
    logic [1:0]  slot_active_reg, slot_active_next;

    // Output register and skid register
    result_t     out_res_reg,  out_res_next;
    logic        out_valid_reg, out_valid_next;
    result_t     skid_res_reg, skid_res_next;
    logic        skid_valid_reg, skid_valid_next;

    // Datapath signals
    logic        in_fire;
    logic        out_fire;
    logic [5:0]  cnt_eff;
    logic        health_eff, reg_eff, token_eff;
    logic [5:0]  cnt_new;
    logic        health_new, reg_new, token_new;
    logic [5:0]  digit_pos;
    logic [4:0]  digit_idx;
    logic [127:0] token_all;
    logic [7:0]  exp_char;
    logic        tok_hit;
    logic [47:0] src_ep;
    logic        own0, own1;
    logic        reg_hit;
    logic        reg_idx;
    logic [1:0]  active_after;
    result_t     res;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign out_valid  = out_valid_reg;
    assign verdict    = out_res_reg.verdict;
    assign dest_ip    = out_res_reg.dest_ip;
    assign dest_port  = out_res_reg.dest_port;
    assign slot_index = out_res_reg.slot_index;

    assign src_ep    = {src_ip, src_port};
    assign token_all = {token_high_reg, token_low_reg};

    // Token digit for the current byte: digit 0 sits in the top nibble of token_high
    assign digit_pos = cnt_eff - MAGIC_LEN;
    assign digit_idx = digit_pos[4:0];
    assign exp_char  = hex_char(token_all[{~digit_idx, 2'b00} +: 4]);
    assign tok_hit   = (to_lower(data_byte) == exp_char);

    // First active slot holding the sender's endpoint
    assign own0 = slot_active_reg[0] && (slot_ep_reg[0] == src_ep);
    assign own1 = slot_active_reg[1] && (slot_ep_reg[1] == src_ep) && !own0;

    // Match the byte: first_byte starts a fresh datagram before this byte counts
    always_comb
    begin
        cnt_eff    = first_byte ? 6'd0 : byte_count_reg;
        health_eff = first_byte ? 1'b0 : health_ok_reg;
        reg_eff    = first_byte ? 1'b0 : reg_ok_reg;
        token_eff  = first_byte ? 1'b0 : token_ok_reg;

        health_new = health_eff;
        reg_new    = reg_eff;
        token_new  = token_eff;
        if (cnt_eff < MAGIC_LEN)
        begin
            health_new = (data_byte == HEALTH_MAGIC[cnt_eff[1:0]]) &&
                         ((cnt_eff == 6'd0) || health_eff);
            reg_new    = (data_byte == REG_MAGIC[cnt_eff[1:0]]) &&
                         ((cnt_eff == 6'd0) || reg_eff);
        end
        else if (cnt_eff < REG_LEN)
        begin
            token_new = tok_hit && ((cnt_eff == MAGIC_LEN) || token_eff);
        end

        cnt_new = (cnt_eff < COUNT_SAT) ? cnt_eff + 6'd1 : cnt_eff;
    end

    // Verdict and slot update for a last byte
    always_comb
    begin
        res              = '0;
        res.verdict      = VERDICT_DROP;
        slot_ep_next     = slot_ep_reg;
        slot_active_next = slot_active_reg;
        reg_hit          = 1'b0;
        reg_idx          = 1'b0;
        active_after     = slot_active_reg;

        // Pick the sender's own slot first, then the first free one
        if (own0)
        begin
            reg_hit = 1'b1;
            reg_idx = 1'b0;
        end
        else if (own1)
        begin
            reg_hit = 1'b1;
            reg_idx = 1'b1;
        end
        else if (!slot_active_reg[0])
        begin
            reg_hit = 1'b1;
            reg_idx = 1'b0;
        end
        else if (!slot_active_reg[1])
        begin
            reg_hit = 1'b1;
            reg_idx = 1'b1;
        end
        active_after[reg_idx] = 1'b1;

        if (cnt_new == HEALTH_LEN && health_new)
        begin
            res.verdict   = VERDICT_HEALTH;
            res.dest_ip   = src_ip;
            res.dest_port = src_port;
        end
        else if (cnt_new == REG_LEN && reg_new)
        begin
            // Bad token or no slot free: drop
            if (token_new && reg_hit)
            begin
                if (in_fire && last_byte)
                begin
                    slot_ep_next[reg_idx]     = src_ep;
                    slot_active_next[reg_idx] = 1'b1;
                end
                res.verdict    = (&active_after) ? VERDICT_REGISTERED : VERDICT_WAITING;
                res.dest_ip    = src_ip;
                res.dest_port  = src_port;
                res.slot_index = reg_idx;
            end
        end
        else if ((own0 || own1) && slot_active_reg[own0])
        begin
            // Forward to the partner slot: slot 1 when the sender holds slot 0
            res.verdict    = VERDICT_FORWARD;
            res.dest_ip    = slot_ep_reg[own0][47:16];
            res.dest_port  = slot_ep_reg[own0][15:0];
            res.slot_index = own1;
        end
    end

    // Datagram state: hold when idle, clear after a last byte
    always_comb
    begin
        byte_count_next = byte_count_reg;
        health_ok_next  = health_ok_reg;
        reg_ok_next     = reg_ok_reg;
        token_ok_next   = token_ok_reg;
        if (in_fire)
        begin
            if (last_byte)
            begin
                byte_count_next = 6'd0;
                health_ok_next  = 1'b0;
                reg_ok_next     = 1'b0;
                token_ok_next   = 1'b0;
            end
            else
            begin
                byte_count_next = cnt_new;
                health_ok_next  = health_new;
                reg_ok_next     = reg_new;
                token_ok_next   = token_new;
            end
        end
    end

    // Output register and skid: advance the skid entry first to keep order
    always_comb
    begin
        out_res_next    = out_res_reg;
        out_valid_next  = out_valid_reg;
        skid_res_next   = skid_res_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_res_next    = skid_res_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire && last_byte)
            begin
                out_res_next   = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire && last_byte)
        begin
            skid_res_next   = res;
            skid_valid_next = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_high_reg  <= '0;
            token_low_reg   <= '0;
            byte_count_reg  <= '0;
            health_ok_reg   <= 1'b0;
            reg_ok_reg      <= 1'b0;
            token_ok_reg    <= 1'b0;
            slot_ep_reg[0]  <= '0;
            slot_ep_reg[1]  <= '0;
            slot_active_reg <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && cfg_index == CFG_TOKEN_HIGH)
                token_high_reg <= cfg_wdata;
            if (cfg_write_en && cfg_index == CFG_TOKEN_LOW)
                token_low_reg <= cfg_wdata;
            byte_count_reg  <= byte_count_next;
            health_ok_reg   <= health_ok_next;
            reg_ok_reg      <= reg_ok_next;
            token_ok_reg    <= token_ok_next;
            slot_ep_reg     <= slot_ep_next;
            slot_active_reg <= slot_active_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule
